// ----- design/eosg_pkg.sv -----
// shared constants and types of the ellipse outline span generator
package eosg_pkg;

	localparam int N_RECT     = 8;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
	localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
	localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RUN,
		PH_SETUP_MUL,
		PH_SETUP_ERR
	} phase_t;

	// one set of raw rectangles handed from the iteration stage to the clip stage
	typedef struct packed {
		logic              valid;
		logic              fin;
		logic [N_RECT-1:0] mask;
	} set_ctrl_t;

endpackage

// ----- design/ellipse_outline_span_generator.sv -----
// Ellipse outline span generator: a start item (tuser 0) loads a bounding box and sets up
// the midpoint error terms (an empty box sends one all-zero finishing rectangle); each step
// item (tuser 1) runs one iteration and sends 0 to 8 clipped outline rectangles, the last
// one of an item with tlast, the last one of the outline with tuser. An item is registered
// on input, turned by the iteration stage into a registered rectangle set, then clipped
// and packed into an 8-entry result buffer. The buffer sends one rectangle per cycle while
// m_axis_tready is high and takes the next set as its last one leaves. After a start with
// a non-empty box the iteration stage takes no item while it forms the a^2 * b product and
// then sets up the error terms. The clip rectangle is written over APB at byte addresses
// 0, 4, 8 and 12 (left, top, right, bottom) and should only change while the block is idle.
module ellipse_outline_span_generator #(
	parameter int COORD_BITS = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// box_left, box_top, box_right, box_bottom
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]            s_axis_tdata,
	// operation
	input  logic                                         s_axis_tuser,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// span_left, span_top, span_width, span_height
	output logic [((4*COORD_BITS+7)/8)*8-1:0]            m_axis_tdata,
	output logic                                         m_axis_tlast,
	// finished
	output logic                                         m_axis_tuser,
	input  logic                                         psel,
	input  logic                                         penable,
	input  logic                                         pwrite,
	input  logic [eosg_pkg::APB_ADDR_W-1:0]              paddr,
	input  logic [eosg_pkg::APB_DATA_W-1:0]              pwdata,
	output logic [eosg_pkg::APB_DATA_W-1:0]              prdata,
	output logic                                         pready
);
	import eosg_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int RW   = CB + 3;
	localparam int TD_W = ((4 * CB + 7) / 8) * 8;

	logic signed [CB-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic                 reg_wr;
	logic [1:0]           reg_idx;

	logic                 valid_s1, op_s1;
	logic signed [CB-1:0] box_l_s1, box_t_s1, box_r_s1, box_b_s1;
	logic                 in_fire, item_take;

	set_ctrl_t                 set_s2;
	logic                      set_take;
	logic [N_RECT-1:0][RW-1:0] rect_l_s2, rect_t_s2, rect_r_s2, rect_b_s2;

	logic signed [CB-1:0] out_left, out_top;
	logic [CB-1:0]        out_width, out_height;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= '0;
			clip_bottom_q <= '0;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_CLIP_LEFT:   clip_left_q   <= $signed(pwdata[CB-1:0]);
				REG_CLIP_TOP:    clip_top_q    <= $signed(pwdata[CB-1:0]);
				REG_CLIP_RIGHT:  clip_right_q  <= $signed(pwdata[CB-1:0]);
				REG_CLIP_BOTTOM: clip_bottom_q <= $signed(pwdata[CB-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CLIP_LEFT:   prdata = APB_DATA_W'(clip_left_q);
			REG_CLIP_TOP:    prdata = APB_DATA_W'(clip_top_q);
			REG_CLIP_RIGHT:  prdata = APB_DATA_W'(clip_right_q);
			REG_CLIP_BOTTOM: prdata = APB_DATA_W'(clip_bottom_q);
			default:         prdata = '0;
		endcase
	end

	// input register
	assign s_axis_tready = !valid_s1 || item_take;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (item_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= s_axis_tuser;
			box_l_s1 <= $signed(s_axis_tdata[CB-1:0]);
			box_t_s1 <= $signed(s_axis_tdata[2*CB-1:CB]);
			box_r_s1 <= $signed(s_axis_tdata[3*CB-1:2*CB]);
			box_b_s1 <= $signed(s_axis_tdata[4*CB-1:3*CB]);
		end
	end

	eosg_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.item_take   (item_take),
		.item_op     (op_s1),
		.item_left   (box_l_s1),
		.item_top    (box_t_s1),
		.item_right  (box_r_s1),
		.item_bottom (box_b_s1),
		.set_s2      (set_s2),
		.set_take    (set_take),
		.rect_l_s2   (rect_l_s2),
		.rect_t_s2   (rect_t_s2),
		.rect_r_s2   (rect_r_s2),
		.rect_b_s2   (rect_b_s2)
	);

	eosg_span #(
		.COORD_BITS (COORD_BITS)
	) u_span (
		.clk         (clk),
		.arst_n      (arst_n),
		.clip_left   (clip_left_q),
		.clip_top    (clip_top_q),
		.clip_right  (clip_right_q),
		.clip_bottom (clip_bottom_q),
		.set_s2      (set_s2),
		.set_take    (set_take),
		.rect_l_s2   (rect_l_s2),
		.rect_t_s2   (rect_t_s2),
		.rect_r_s2   (rect_r_s2),
		.rect_b_s2   (rect_b_s2),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_left    (out_left),
		.out_top     (out_top),
		.out_width   (out_width),
		.out_height  (out_height),
		.out_last    (m_axis_tlast),
		.out_fin     (m_axis_tuser)
	);

	assign m_axis_tdata = TD_W'({out_height, out_width, out_top, out_left});

endmodule

// ----- design/eosg_step.sv -----
// midpoint ellipse iteration stage: error terms, start setup and raw outline rectangles
module eosg_step #(
	parameter int COORD_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          item_valid,
	output logic                                          item_take,
	input  logic                                          item_op,
	input  logic signed [COORD_BITS-1:0]                  item_left,
	input  logic signed [COORD_BITS-1:0]                  item_top,
	input  logic signed [COORD_BITS-1:0]                  item_right,
	input  logic signed [COORD_BITS-1:0]                  item_bottom,
	output eosg_pkg::set_ctrl_t                           set_s2,
	input  logic                                          set_take,
	output logic [eosg_pkg::N_RECT-1:0][COORD_BITS+2:0]  rect_l_s2,
	output logic [eosg_pkg::N_RECT-1:0][COORD_BITS+2:0]  rect_t_s2,
	output logic [eosg_pkg::N_RECT-1:0][COORD_BITS+2:0]  rect_r_s2,
	output logic [eosg_pkg::N_RECT-1:0][COORD_BITS+2:0]  rect_b_s2
);
	import eosg_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int RW = CB + 3;       // raw rectangle coordinates
	localparam int AW = CB - 1;       // half axis
	localparam int SW = 2 * CB - 2;   // half axis squared
	localparam int MW = 3 * CB - 3;   // a^2 * b
	localparam int EW = 3 * CB + 4;   // error terms and increments

	phase_t phase_q, phase_d;

	logic signed [CB:0]   cx_q, cy_q;
	logic [AW-1:0]        hw_q, hh_q;
	logic                 wo_q;
	logic [1:0]           he_q;
	logic [CB-1:0]        x_q, y_q, px_q, py_q;
	logic [SW-1:0]        a2_q, b2_q;
	logic [MW-1:0]        m_q;
	// p tracks 2b^2 * x, q tracks 2a^2 * y
	logic signed [EW-1:0] p_q, q_q, es_q, et_q;

	// start decode
	logic signed [CB:0]   wd, ht, cx_new, cy_new;
	logic [AW-1:0]        a_new, bh_new;
	logic [SW-1:0]        a2_new, b2_new;
	logic [MW-1:0]        m_new;
	logic [1:0]           he_new;
	logic                 box_empty;

	// error term arithmetic
	logic signed [EW-1:0] aa_e, bb_e, a2_e, b2_e, m_e;
	logic signed [EW-1:0] ds, dt, ey, ex;
	logic                 br_s, br_t;

	// control
	logic run_ok, s2_free, is_start;
	logic do_start, do_iter, do_fin, emit;

	// geometry
	logic signed [RW-1:0] cx_e, cy_e, x_e, y_e, px_e, py_e, hw_e, wo_e, he_e, one;
	logic signed [RW-1:0] xn, yn, w, h;
	logic                 thin;
	logic signed [RW-1:0] gxl [2];
	logic signed [RW-1:0] gxr [2];
	logic signed [RW-1:0] gyt [2];
	logic signed [RW-1:0] gyb [2];
	logic signed [RW-1:0] gw [2];
	logic signed [RW-1:0] gh [2];
	logic signed [RW-1:0] fl0, fl1, ft, fsw, fsh;
	logic [N_RECT-1:0][RW-1:0] rl_d, rt_d, rr_d, rb_d;
	logic [N_RECT-1:0]         mask_d;

	assign box_empty = (item_right <= item_left) || (item_bottom <= item_top);
	assign wd        = (CB+1)'(item_right) - (CB+1)'(item_left) - (CB+1)'(1);
	assign ht        = (CB+1)'(item_bottom) - (CB+1)'(item_top) - (CB+1)'(1);
	assign a_new     = wd[CB-1:1];
	assign bh_new    = ht[CB-1:1];
	assign he_new    = {1'b0, ht[0]} + 2'd1;
	assign cx_new    = (CB+1)'(item_left) + $signed((CB+1)'(a_new));
	assign cy_new    = (CB+1)'(item_top) + $signed((CB+1)'(bh_new));
	assign a2_new    = SW'(a_new) * SW'(a_new);
	assign b2_new    = SW'(bh_new) * SW'(bh_new);
	assign m_new     = MW'(a2_q) * MW'(hh_q);

	assign aa_e = EW'({a2_q, 1'b0});
	assign bb_e = EW'({b2_q, 1'b0});
	assign a2_e = EW'(a2_q);
	assign b2_e = EW'(b2_q);
	assign m_e  = EW'(m_q);

	assign ds = (p_q <<< 1) + bb_e + (bb_e <<< 1);
	assign dt = (p_q <<< 1) + (bb_e <<< 1);
	assign ey = (q_q <<< 1) - aa_e - (aa_e <<< 1);
	assign ex = (q_q <<< 1) - (aa_e <<< 1);

	assign br_s = es_q[EW-1];
	assign br_t = !es_q[EW-1] && et_q[EW-1];

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE, PH_RUN: begin
				if (do_start) begin
					phase_d = box_empty ? PH_IDLE : PH_SETUP_MUL;
				end else if (do_fin) begin
					phase_d = PH_IDLE;
				end
			end
			PH_SETUP_MUL: phase_d = PH_SETUP_ERR;
			PH_SETUP_ERR: phase_d = PH_RUN;
			default:      phase_d = PH_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		run_ok    = (phase_q == PH_IDLE) || (phase_q == PH_RUN);
		s2_free   = !set_s2.valid || set_take;
		is_start  = item_op == OP_START;
		item_take = item_valid && run_ok && s2_free;
		do_start  = item_take && is_start;
		do_iter   = item_take && !is_start && (phase_q == PH_RUN) && (y_q != '0);
		do_fin    = item_take && !is_start && (phase_q == PH_RUN) && (y_q == '0);
		emit      = (do_start && box_empty) || do_fin || (do_iter && br_t);
	end

	assign cx_e = RW'(cx_q);
	assign cy_e = RW'(cy_q);
	assign x_e  = RW'(x_q);
	assign y_e  = RW'(y_q);
	assign px_e = RW'(px_q);
	assign py_e = RW'(py_q);
	assign hw_e = RW'(hw_q);
	assign wo_e = RW'(wo_q);
	assign he_e = RW'(he_q);
	assign one  = RW'(1);

	assign xn   = x_e + one;
	assign yn   = y_e - one;
	assign w    = xn - px_e;
	assign h    = py_e - yn;
	assign thin = w[1] & h[1];

	assign fl0 = cx_e - hw_e;
	assign fl1 = cx_e + px_e + wo_e;
	assign ft  = cy_e - py_e;
	assign fsw = hw_e - px_e + one;
	assign fsh = (py_e <<< 1) + he_e;

	// offsets of the quadrant pieces; thin corners split into two unit groups
	always_comb begin
		gxl[0] = thin ? (one + one - xn) : (one - xn);
		gxr[0] = px_e + wo_e;
		gyt[0] = -py_e;
		gyb[0] = thin ? (py_e - one + he_e) : (yn + he_e);
		gw[0]  = thin ? one : w;
		gh[0]  = thin ? one : h;
		gxl[1] = one - xn;
		gxr[1] = x_e + wo_e;
		gyt[1] = -y_e;
		gyb[1] = yn + he_e;
		gw[1]  = one;
		gh[1]  = one;
	end

	always_comb begin
		int k;
		logic signed [RW-1:0] xo, yo;
		k  = 0;
		xo = '0;
		yo = '0;
		for (int g = 0; g < 2; g++) begin
			for (int qd = 0; qd < 4; qd++) begin
				k = g * 4 + qd;
				xo = (qd < 2) ? gxr[g] : gxl[g];
				yo = (qd == 0 || qd == 3) ? gyt[g] : gyb[g];
				rl_d[k] = cx_e + xo;
				rt_d[k] = cy_e + yo;
				rr_d[k] = cx_e + xo + gw[g];
				rb_d[k] = cy_e + yo + gh[g];
			end
		end
		if (do_fin) begin
			rl_d[0] = fl0;
			rr_d[0] = fl0 + fsw;
			rl_d[1] = fl1;
			rr_d[1] = fl1 + fsw;
			rt_d[0] = ft;
			rb_d[0] = ft + fsh;
			rt_d[1] = ft;
			rb_d[1] = ft + fsh;
		end
	end

	always_comb begin
		if (do_fin) begin
			mask_d = N_RECT'(3);
		end else if (do_iter) begin
			mask_d = thin ? '1 : N_RECT'(15);
		end else begin
			mask_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			set_s2  <= '0;
		end else begin
			phase_q <= phase_d;
			if (emit) begin
				set_s2.valid <= 1'b1;
				set_s2.fin   <= do_fin || do_start;
				set_s2.mask  <= mask_d;
			end else if (set_take) begin
				set_s2.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rect_l_s2 <= rl_d;
			rect_t_s2 <= rt_d;
			rect_r_s2 <= rr_d;
			rect_b_s2 <= rb_d;
		end
		if (do_start && !box_empty) begin
			hw_q <= a_new;
			hh_q <= bh_new;
			wo_q <= wd[0];
			he_q <= he_new;
			cx_q <= cx_new;
			cy_q <= cy_new;
			a2_q <= a2_new;
			b2_q <= b2_new;
		end
		if (phase_q == PH_SETUP_MUL) begin
			m_q <= m_new;
		end
		if (do_start && !box_empty) begin
			x_q  <= '0;
			y_q  <= CB'(bh_new);
			px_q <= '0;
			py_q <= CB'(bh_new);
		end else if (do_iter) begin
			if (br_s) begin
				x_q <= x_q + CB'(1);
			end else if (br_t) begin
				x_q  <= x_q + CB'(1);
				y_q  <= y_q - CB'(1);
				px_q <= x_q + CB'(1);
				py_q <= y_q - CB'(1);
			end else begin
				y_q <= y_q - CB'(1);
			end
		end
		if (phase_q == PH_SETUP_ERR) begin
			p_q  <= '0;
			q_q  <= m_e <<< 1;
			es_q <= a2_e - (m_e <<< 1) + bb_e;
			et_q <= b2_e - (m_e <<< 2) + aa_e;
		end else if (do_iter) begin
			if (br_s) begin
				es_q <= es_q + ds;
				et_q <= et_q + dt;
				p_q  <= p_q + bb_e;
			end else if (br_t) begin
				es_q <= es_q + ds - ex;
				et_q <= et_q + dt - ey;
				p_q  <= p_q + bb_e;
				q_q  <= q_q - aa_e;
			end else begin
				et_q <= et_q - ey;
				es_q <= es_q - ex;
				q_q  <= q_q - aa_e;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_setup_order: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SETUP_MUL |=> phase_q == PH_SETUP_ERR)
		else $error("setup multiply not followed by error term setup");

	a_set_hold: assert property (@(posedge clk) disable iff (!arst_n)
		set_s2.valid && !set_take |=> set_s2.valid && $stable(set_s2.mask))
		else $error("rectangle set changed before it was taken");

	a_no_take_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SETUP_MUL || phase_q == PH_SETUP_ERR |-> !item_take)
		else $error("item taken during start setup");
`endif

endmodule

// ----- design/eosg_span.sv -----
// clip stage and result buffer: clips raw rectangles, packs the survivors, sends them out
module eosg_span #(
	parameter int COORD_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic signed [COORD_BITS-1:0]                  clip_left,
	input  logic signed [COORD_BITS-1:0]                  clip_top,
	input  logic signed [COORD_BITS-1:0]                  clip_right,
	input  logic signed [COORD_BITS-1:0]                  clip_bottom,
	input  eosg_pkg::set_ctrl_t                           set_s2,
	output logic                                          set_take,
	input  logic [eosg_pkg::N_RECT-1:0][COORD_BITS+2:0]  rect_l_s2,
	input  logic [eosg_pkg::N_RECT-1:0][COORD_BITS+2:0]  rect_t_s2,
	input  logic [eosg_pkg::N_RECT-1:0][COORD_BITS+2:0]  rect_r_s2,
	input  logic [eosg_pkg::N_RECT-1:0][COORD_BITS+2:0]  rect_b_s2,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic signed [COORD_BITS-1:0]                  out_left,
	output logic signed [COORD_BITS-1:0]                  out_top,
	output logic [COORD_BITS-1:0]                         out_width,
	output logic [COORD_BITS-1:0]                         out_height,
	output logic                                          out_last,
	output logic                                          out_fin
);
	import eosg_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int RW = CB + 3;
	localparam logic signed [RW-1:0] LIM_LO = {{(RW-CB+1){1'b1}}, {(CB-1){1'b0}}};
	localparam logic signed [RW-1:0] LIM_HI = {{(RW-CB+1){1'b0}}, {(CB-1){1'b1}}};

	logic                 clip_on;
	logic signed [RW-1:0] cl_e, ct_e, cr_e, cb_e;
	logic [N_RECT-1:0]    keep;
	logic [CB-1:0]        kl [N_RECT];
	logic [CB-1:0]        kt [N_RECT];
	logic [CB-1:0]        kw [N_RECT];
	logic [CB-1:0]        kh [N_RECT];
	logic [3:0]           pre [N_RECT+1];
	logic [CB-1:0]        sl [N_RECT];
	logic [CB-1:0]        st [N_RECT];
	logic [CB-1:0]        sw [N_RECT];
	logic [CB-1:0]        sh [N_RECT];
	logic [3:0]           n_eff;

	logic [CB-1:0]        ob_l_q [N_RECT];
	logic [CB-1:0]        ob_t_q [N_RECT];
	logic [CB-1:0]        ob_w_q [N_RECT];
	logic [CB-1:0]        ob_h_q [N_RECT];
	logic [3:0]           cnt_q;
	logic                 fin_q;
	logic                 out_fire;

	// an empty clip rectangle turns clipping off
	assign clip_on = (clip_right > clip_left) && (clip_bottom > clip_top);
	assign cl_e    = RW'(clip_left);
	assign ct_e    = RW'(clip_top);
	assign cr_e    = RW'(clip_right);
	assign cb_e    = RW'(clip_bottom);

	always_comb begin
		logic signed [RW-1:0] l, t, r, b;
		l = '0;
		t = '0;
		r = '0;
		b = '0;
		for (int i = 0; i < N_RECT; i++) begin
			l = $signed(rect_l_s2[i]);
			t = $signed(rect_t_s2[i]);
			r = $signed(rect_r_s2[i]);
			b = $signed(rect_b_s2[i]);
			if (clip_on) begin
				if (cl_e > l) l = cl_e;
				if (ct_e > t) t = ct_e;
				if (cr_e < r) r = cr_e;
				if (cb_e < b) b = cb_e;
			end
			if (LIM_LO > l) l = LIM_LO;
			if (LIM_LO > t) t = LIM_LO;
			if (LIM_HI < r) r = LIM_HI;
			if (LIM_HI < b) b = LIM_HI;
			keep[i] = set_s2.mask[i] && (r > l) && (b > t);
			kl[i]   = CB'(l);
			kt[i]   = CB'(t);
			kw[i]   = CB'(r - l);
			kh[i]   = CB'(b - t);
		end
	end

	// pack kept rectangles to the front in order
	always_comb begin
		pre[0] = '0;
		for (int i = 0; i < N_RECT; i++) begin
			pre[i+1] = pre[i] + 4'(keep[i]);
		end
		for (int j = 0; j < N_RECT; j++) begin
			sl[j] = '0;
			st[j] = '0;
			sw[j] = '0;
			sh[j] = '0;
			for (int i = 0; i < N_RECT; i++) begin
				if (keep[i] && pre[i] == 4'(j)) begin
					sl[j] = kl[i];
					st[j] = kt[i];
					sw[j] = kw[i];
					sh[j] = kh[i];
				end
			end
		end
		// finishing with nothing left: slot 0 is already the all-zero marker
		if (set_s2.fin && pre[N_RECT] == '0) begin
			n_eff = 4'd1;
		end else begin
			n_eff = pre[N_RECT];
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_fire  = out_valid && out_ready;
	assign set_take  = set_s2.valid && ((cnt_q == '0) || (cnt_q == 4'd1 && out_ready));
	assign out_left  = $signed(ob_l_q[0]);
	assign out_top   = $signed(ob_t_q[0]);
	assign out_width  = ob_w_q[0];
	assign out_height = ob_h_q[0];
	assign out_last  = cnt_q == 4'd1;
	assign out_fin   = fin_q && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (set_take) begin
			cnt_q <= n_eff;
			fin_q <= set_s2.fin;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (set_take) begin
			ob_l_q <= sl;
			ob_t_q <= st;
			ob_w_q <= sw;
			ob_h_q <= sh;
		end else if (out_fire) begin
			for (int j = 0; j < N_RECT - 1; j++) begin
				ob_l_q[j] <= ob_l_q[j+1];
				ob_t_q[j] <= ob_t_q[j+1];
				ob_w_q[j] <= ob_w_q[j+1];
				ob_h_q[j] <= ob_h_q[j+1];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_fin_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		set_take && set_s2.fin |=> out_valid && $rose(out_last) || out_valid)
		else $error("finishing set produced no item");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && cnt_q > 4'd1 |=> cnt_q == $past(cnt_q) - 4'd1)
		else $error("buffer reloaded while items were still queued");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(N_RECT))
		else $error("result count out of range");
`endif

endmodule

// ----- verif/tb_ellipse_outline_span_generator.sv -----
// testbench of the ellipse outline span generator: random ellipses checked against a predictor
`timescale 1ns / 100ps

module tb_ellipse_outline_span_generator;
	import eosg_pkg::*;

	localparam int     HOLD_CYCLES   = 300;
	localparam int     SETTLE_CYCLES = 16;
	localparam longint COORD_LO      = -32768;
	localparam longint COORD_HI      = 32767;

	typedef struct packed {
		logic        op;
		logic [15:0] bottom, right, top, left;
	} box_item_t;

	typedef struct packed {
		logic [15:0] left, top, width, height;
		logic        last, fin;
	} span_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// box_left, box_top, box_right, box_bottom
	logic [63:0] s_axis_tdata = '0;
	// operation
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// span_left, span_top, span_width, span_height
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	// finished
	logic        m_axis_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic        pready;

	box_item_t pending_items[$];
	span_t     expected_spans[$];
	int        items_queued = 0;
	int        mismatches = 0;
	int        send_gap_pct = 0;
	int        recv_stall_pct = 0;
	bit        hold_on = 1'b0;
	int        hold_count = 0;
	logic      in_fire = 1'b0;

	// clip window as the block should hold it
	longint win_left = 0, win_top = 0, win_right = 0, win_bottom = 0;

	// ellipse tracker
	phase_t ellipse_phase = PH_IDLE;
	longint ctr_x, ctr_y, semi_w, semi_h, odd_w, extra_h;
	longint x_now, y_now, x_prev, y_prev, two_aa, two_bb, err_x, err_y;
	int     run_len;

	ellipse_outline_span_generator #(.COORD_BITS(16)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void emit_rect(longint l, longint t, longint w, longint h);
		span_t s;
		if (run_len < N_RECT) begin
			s.left = l[15:0];
			s.top = t[15:0];
			s.width = w[15:0];
			s.height = h[15:0];
			s.last = 1'b0;
			s.fin = 1'b0;
			expected_spans.push_back(s);
			run_len++;
		end
	endfunction

	function automatic void mark_item_end(bit fin);
		span_t s;
		if (run_len > 0) begin
			s = expected_spans.pop_back();
			s.last = 1'b1;
			s.fin = fin;
			expected_spans.push_back(s);
		end
	endfunction

	function automatic void clip_fill(longint x, longint y, longint w, longint h);
		longint l, t, r, b;
		l = x;
		t = y;
		r = x + w;
		b = y + h;
		if (win_right > win_left && win_bottom > win_top) begin
			if (l < win_left) l = win_left;
			if (t < win_top) t = win_top;
			if (r > win_right) r = win_right;
			if (b > win_bottom) b = win_bottom;
		end
		// coordinate range, right edge exclusive
		if (l < COORD_LO) l = COORD_LO;
		if (t < COORD_LO) t = COORD_LO;
		if (r > COORD_HI) r = COORD_HI;
		if (b > COORD_HI) b = COORD_HI;
		if (r > l && b > t)
			emit_rect(l, t, r - l, b - t);
	endfunction

	function automatic void mirror_quadrants(longint xl, longint xr, longint yt, longint yb,
			longint w, longint h);
		clip_fill(xr + ctr_x, yt + ctr_y, w, h);
		clip_fill(xr + ctr_x, yb + ctr_y, w, h);
		clip_fill(xl + ctr_x, yb + ctr_y, w, h);
		clip_fill(xl + ctr_x, yt + ctr_y, w, h);
	endfunction

	function automatic void advance_iteration();
		longint w, h;
		if (err_x < 0) begin
			err_x += two_bb * (2 * x_now + 3);
			x_now++;
			err_y += 2 * two_bb * x_now;
		end else if (err_y < 0) begin
			err_x += two_bb * (2 * x_now + 3) - 2 * two_aa * (y_now - 1);
			x_now++;
			err_y += 2 * two_bb * x_now - two_aa * (2 * y_now - 3);
			y_now--;
			w = x_now - x_prev;
			h = y_prev - y_now;
			// thin corner: split into single pixels
			if (w[1] && h[1]) begin
				mirror_quadrants(-x_now + 2, x_prev + odd_w, -y_prev,
					y_prev - 1 + extra_h, 1, 1);
				mirror_quadrants(-x_now + 1, x_now - 1 + odd_w, -y_now - 1,
					y_now + extra_h, 1, 1);
			end else begin
				mirror_quadrants(-x_now + 1, x_prev + odd_w, -y_prev,
					y_prev - h + extra_h, w, h);
			end
			x_prev = x_now;
			y_prev = y_now;
		end else begin
			err_y -= two_aa * (2 * y_now - 3);
			y_now--;
			err_x -= 2 * two_aa * y_now;
		end
		mark_item_end(1'b0);
	endfunction

	function automatic void close_outline();
		longint sw, sh;
		sw = semi_w - x_prev + 1;
		sh = 2 * y_prev + extra_h;
		clip_fill(ctr_x - semi_w, ctr_y - y_prev, sw, sh);
		clip_fill(ctr_x + x_prev + odd_w, ctr_y - y_prev, sw, sh);
		if (run_len == 0)
			emit_rect(0, 0, 0, 0);
		mark_item_end(1'b1);
		ellipse_phase = PH_IDLE;
	endfunction

	function automatic void predict_spans(logic op, logic [63:0] d);
		longint l, t, r, b, wd, ht;
		run_len = 0;
		if (op == OP_START) begin
			l = longint'($signed(d[15:0]));
			t = longint'($signed(d[31:16]));
			r = longint'($signed(d[47:32]));
			b = longint'($signed(d[63:48]));
			if (r <= l || b <= t) begin
				ellipse_phase = PH_IDLE;
				emit_rect(0, 0, 0, 0);
				mark_item_end(1'b1);
			end else begin
				wd = r - l - 1;
				ht = b - t - 1;
				semi_w = wd / 2;
				semi_h = ht / 2;
				two_aa = 2 * semi_w * semi_w;
				two_bb = 2 * semi_h * semi_h;
				odd_w = wd & 1;
				extra_h = (ht & 1) + 1;
				ctr_x = l + semi_w;
				ctr_y = t + semi_h;
				x_now = 0;
				y_now = semi_h;
				x_prev = 0;
				y_prev = semi_h;
				err_x = (two_aa / 2) * (1 - 2 * semi_h) + two_bb;
				err_y = two_bb / 2 - two_aa * (2 * semi_h - 1);
				ellipse_phase = PH_RUN;
			end
		end else if (ellipse_phase == PH_RUN) begin
			if (y_now > 0)
				advance_iteration();
			else
				close_outline();
		end
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%h, got 'h%h", name, want, got);
			mismatches++;
		end
	endtask

	// item sender
	always @(negedge clk) begin : feed
		box_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				it = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= it.op;
				s_axis_tdata <= {it.bottom, it.right, it.top, it.left};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(negedge clk) begin
		if (hold_on && hold_count < HOLD_CYCLES)
			hold_count <= hold_count + 1;
	end

	always @(negedge clk) begin
		m_axis_tready <= !(hold_on && hold_count < HOLD_CYCLES) &&
			($urandom_range(99) >= recv_stall_pct);
	end

	// input prediction first, then result check
	always @(posedge clk) begin : watch
		span_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				predict_spans(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_spans.size() == 0) begin
					$error("unexpected span: data 'h%h, last %b, finished %b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
					mismatches++;
				end else begin
					want = expected_spans.pop_front();
					check_field("span_left", want.left, m_axis_tdata[15:0]);
					check_field("span_top", want.top, m_axis_tdata[31:16]);
					check_field("span_width", want.width, m_axis_tdata[47:32]);
					check_field("span_height", want.height, m_axis_tdata[63:48]);
					check_field("last_of_run", {15'b0, want.last}, {15'b0, m_axis_tlast});
					check_field("finished", {15'b0, want.fin}, {15'b0, m_axis_tuser});
				end
			end
		end
	end

	task automatic queue_item(logic op, int l, int t, int r, int b, bit counted);
		box_item_t it;
		it.op = op;
		it.left = l[15:0];
		it.top = t[15:0];
		it.right = r[15:0];
		it.bottom = b[15:0];
		pending_items.push_back(it);
		if (counted)
			items_queued++;
	endtask

	task automatic write_clip(logic [1:0] idx, int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CLIP_LEFT:   win_left = value;
			REG_CLIP_TOP:    win_top = value;
			REG_CLIP_RIGHT:  win_right = value;
			REG_CLIP_BOTTOM: win_bottom = value;
			default: ;
		endcase
	endtask

	task automatic set_window(int l, int t, int r, int b);
		write_clip(REG_CLIP_LEFT, l);
		write_clip(REG_CLIP_TOP, t);
		write_clip(REG_CLIP_RIGHT, r);
		write_clip(REG_CLIP_BOTTOM, b);
	endtask

	// wait until every item is taken and every span seen, then let the pipe empty
	task automatic settle();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_spans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one start followed by its steps, mostly run to the finish
	task automatic queue_random_ellipse();
		int kind, bw, bh, l, t, n, semi_sum;
		bit windowed;
		kind = $urandom_range(99);
		windowed = (win_right > win_left) && (win_bottom > win_top) &&
			(win_right - win_left < 1000) && (win_bottom - win_top < 1000);
		if (kind < 8) begin
			// empty box, then steps that find nothing to do
			l = $urandom_range(60000) - 30000;
			t = $urandom_range(60000) - 30000;
			if ($urandom_range(1))
				queue_item(OP_START, l, t, l - $urandom_range(3), t + $urandom_range(20, 1), 1);
			else
				queue_item(OP_START, l, t, l + $urandom_range(20, 1), t - $urandom_range(3), 1);
			repeat ($urandom_range(2))
				queue_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, 0);
			return;
		end
		if (kind < 12) begin
			bw = $urandom_range(65535, 1000);
			bh = $urandom_range(65535, 1000);
		end else begin
			bw = $urandom_range(26, 1);
			bh = $urandom_range(26, 1);
		end
		if (windowed) begin
			l = int'(win_left) - bw - 10 + $urandom_range(int'(win_right - win_left) + bw + 20);
			t = int'(win_top) - bh - 10 + $urandom_range(int'(win_bottom - win_top) + bh + 20);
		end else begin
			case ($urandom_range(3))
				0: l = -32768;
				1: l = 32767 - bw;
				default: l = -32768 + $urandom_range(65535 - bw);
			endcase
			case ($urandom_range(3))
				0: t = -32768;
				1: t = 32767 - bh;
				default: t = -32768 + $urandom_range(65535 - bh);
			endcase
		end
		if (l < -32768) l = -32768;
		if (l > 32767 - bw) l = 32767 - bw;
		if (t < -32768) t = -32768;
		if (t > 32767 - bh) t = 32767 - bh;
		queue_item(OP_START, l, t, l + bw, t + bh, 1);
		semi_sum = (bw - 1) / 2 + (bh - 1) / 2;
		if (kind < 12)
			n = $urandom_range(6, 1);
		else if ($urandom_range(99) < 75)
			n = semi_sum + 2 + $urandom_range(2);
		else
			n = $urandom_range(semi_sum + 1);
		for (int i = 0; i < n; i++)
			queue_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, i < semi_sum + 2);
	endtask

	initial begin : stimulus
		int phase_end;
		int gap_choice[3];
		gap_choice = '{0, 27, 63};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: step with nothing started, empty boxes, corners of the coordinate range
		queue_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, 0);
		queue_item(OP_START, -32768, 0, -32768, 5, 1);
		queue_item(OP_START, 0, 32767, 10, -32768, 1);
		queue_item(OP_START, -32768, -32768, -32767, -32767, 1);
		queue_item(OP_STEP, 0, 0, 0, 0, 1);
		queue_item(OP_START, 32766, 32766, 32767, 32767, 1);
		queue_item(OP_STEP, -1, -1, -1, -1, 1);
		// full-width box, abandoned by the next start
		queue_item(OP_START, -32768, 32700, 32767, 32767, 1);
		queue_item(OP_STEP, 0, 0, 0, 0, 1);
		queue_item(OP_STEP, 0, 0, 0, 0, 1);
		// odd width, odd height, run past the finish
		queue_item(OP_START, -4, -3, 6, 5, 1);
		repeat (10) queue_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, 1);
		// flat box left running into the next phase
		queue_item(OP_START, 0, 0, 40, 3, 1);
		queue_item(OP_STEP, 0, 0, 0, 0, 1);
		queue_item(OP_STEP, 0, 0, 0, 0, 1);
		settle();

		for (int p = 1; p <= 5; p++) begin
			case (p)
				1: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
					hold_on = 1'b1;
				end
				2: begin
					set_window(-6, -4, 18, 11);
					send_gap_pct = 63;
					recv_stall_pct = 0;
				end
				3: begin
					set_window(-32768, -32768, 32767, 32767);
					send_gap_pct = 0;
					recv_stall_pct = 63;
				end
				4: begin
					// right edge not past left: clipping off
					set_window(200, 0, -200, 50);
					send_gap_pct = 27;
					recv_stall_pct = 27;
				end
				default: begin
					set_window(-100, 50, -100 + $urandom_range(60, 1), 50 + $urandom_range(60, 1));
					send_gap_pct = gap_choice[$urandom_range(2)];
					recv_stall_pct = gap_choice[$urandom_range(2)];
				end
			endcase
			phase_end = items_queued + 58;
			while (items_queued < phase_end)
				queue_random_ellipse();
			settle();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#6000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- ellipse_outline_span_generator.f -----
design/eosg_pkg.sv
design/eosg_step.sv
design/eosg_span.sv
design/ellipse_outline_span_generator.sv
verif/tb_ellipse_outline_span_generator.sv
